FILE: hdl/tcrc_pkg.sv
package tcrc_pkg;

   // Color channel format.
   localparam int CHANNEL_BITS = 8;
   localparam int CH_LEVELS    = 1 << CHANNEL_BITS;
   localparam int CH_MAX       = CH_LEVELS - 1;
   localparam int CH_HALF      = (CH_MAX - 1) / 2;

   // Linear light in Q0.16; full scale needs one integer bit.
   localparam int LUMA_FRAC_BITS = 16;
   localparam int LUMA_W         = LUMA_FRAC_BITS + 1;

   // Contrast ratio in Q5.8.
   localparam int RATIO_INT_BITS  = 5;
   localparam int RATIO_FRAC_BITS = 8;
   localparam int RATIO_BITS      = RATIO_INT_BITS + RATIO_FRAC_BITS;

   typedef logic [CHANNEL_BITS-1:0]         chan_type;
   typedef logic [2:0][CHANNEL_BITS-1:0]    rgb_type;
   typedef logic [LUMA_W-1:0]               luma_type;
   typedef logic [RATIO_BITS-1:0]           ratio_type;
   typedef logic [CH_LEVELS-1:0][LUMA_W-1:0] lin_rom_type;

   localparam chan_type  CHAN_FULL       = '1;
   localparam ratio_type RATIO_ONE       = ratio_type'(1 << RATIO_FRAC_BITS);
   localparam ratio_type RATIO_CAP       = ratio_type'(21 << RATIO_FRAC_BITS);
   localparam ratio_type MIN_RATIO_RESET = ratio_type'(1152);

   // The 0.05 flare term added to both luminances.
   localparam luma_type LUMA_OFF = luma_type'(((1 << LUMA_FRAC_BITS) + 10) / 20);

   // Luminance weights scaled by 10000, and rounding term.
   localparam int W_RED      = 2126;
   localparam int W_GREEN    = 7152;
   localparam int W_BLUE     = 722;
   localparam int LUMA_ROUND = 5000;
   localparam int LUMA_SUM_W = 30;

   // floor(s / 10000) = (s * LUMA_RECIP) >> LUMA_RECIP_SHIFT, exact for s < 2^30.
   localparam int                  RECIP_W          = 31;
   localparam logic [RECIP_W-1:0]  LUMA_RECIP       = 31'd1759218605;
   localparam int                  LUMA_RECIP_SHIFT = 44;
   localparam int                  LUMA_PROD_W      = LUMA_SUM_W + RECIP_W;

   localparam int LUMA_STAGES = 3;

   // Restoring divider: three quotient bits per pipeline stage.
   localparam int DIV_STEPS_PER_STAGE = 3;
   localparam int DIV_STAGES =
      (RATIO_BITS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

   // Register file decode.
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_INDEX_LSB  = 2;
   localparam int CSR_DATA_W     = 32;

   typedef enum logic {
      CSR_HIGH_CONTRAST = 1'b0,
      CSR_MIN_RATIO     = 1'b1
   } csr_index_type;

   // Constants of the sRGB transfer curve table, evaluated at elaboration.
   localparam logic [63:0] LIN_KNEE   = 64'(3928 * CH_MAX);
   localparam logic [63:0] LIN_DEN_LO = 64'(1292 * CH_MAX);
   localparam logic [63:0] LIN_DEN_HI = 64'(1055 * CH_MAX);
   localparam logic [63:0] Q30_ONE    = 64'd1 << 30;

   function automatic logic [63:0] pow5_q30(input logic [63:0] y);
      logic [63:0] y2;
      logic [63:0] y4;
      y2 = (y * y) >> 30;
      y4 = (y2 * y2) >> 30;
      return (y4 * y) >> 30;
   endfunction

   // Linear segment below the knee, else ((c + 0.055) / 1.055) ^ 2.4 taken as
   // t^2 * t^(2/5), with the fifth root found bit by bit in Q30.
   function automatic lin_rom_type build_lin_rom();
      lin_rom_type rom;
      logic [63:0] c;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] y;
      logic [63:0] cand;
      logic [63:0] r;
      for (int k = 0; k < CH_LEVELS; k++) begin
         c = 64'(k);
         if (c * 64'd100000 <= LIN_KNEE) begin
            rom[k] = LUMA_W'((((c * 64'd100) << LUMA_FRAC_BITS) + LIN_DEN_LO / 2)
                             / LIN_DEN_LO);
         end else begin
            t = (((64'd1000 * c + 64'(55 * CH_MAX)) << 30) + LIN_DEN_HI / 2)
                / LIN_DEN_HI;
            if (t > Q30_ONE) begin
               t = Q30_ONE;
            end
            t2 = (t * t) >> 30;
            y  = '0;
            for (int b = 30; b >= 0; b--) begin
               cand = y | (64'd1 << b);
               if (cand <= Q30_ONE && pow5_q30(cand) <= t2) begin
                  y = cand;
               end
            end
            r = (t2 * y) >> 30;
            rom[k] = LUMA_W'((r + (64'd1 << (29 - LUMA_FRAC_BITS)))
                             >> (30 - LUMA_FRAC_BITS));
         end
      end
      return rom;
   endfunction

   localparam lin_rom_type LIN_ROM = build_lin_rom();

endpackage

FILE: hdl/text_contrast_readability_check.sv
// Text contrast readability check. Each request beat carries an RGBA ink
// color, a token background and an alternate (current line) background; each
// response beat returns the WCAG contrast ratio of the ink against both
// backgrounds in Q5.8 (1.0 to 21.0, rounded down), an unreadable flag (ink
// not fully opaque, or either ratio below min_ratio) and a clear_format flag
// (unreadable, or high-contrast mode set). Translucent backgrounds are
// composited over white and the ink over each background before the
// luminance is taken. The block is a twelve-stage pipeline with no state
// between items: it accepts one beat per clock unless backpressure holds
// it, and much of its depth lies in the 13-bit restoring divider that
// forms the ratio three quotient bits per stage. Backpressure ripples
// stage by stage, so empty stages fill up while the response is stalled
// and nothing is dropped or duplicated. Registers sit at byte address 0
// (high_contrast_mode, bit 0, reset 0) and 4 (min_ratio, bits 12:0,
// reset 1152 = 4.5); write them only while the pipeline is empty.
module text_contrast_readability_check import tcrc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  chan_type              req_ink_red,
   input  chan_type              req_ink_green,
   input  chan_type              req_ink_blue,
   input  chan_type              req_ink_alpha,
   input  chan_type              req_back_red,
   input  chan_type              req_back_green,
   input  chan_type              req_back_blue,
   input  chan_type              req_back_alpha,
   input  chan_type              req_alt_red,
   input  chan_type              req_alt_green,
   input  chan_type              req_alt_blue,
   input  chan_type              req_alt_alpha,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_clear_format,
   output logic                  rsp_unreadable,
   output ratio_type             rsp_ratio_main,
   output ratio_type             rsp_ratio_alt,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Pipeline stage map. Each stage has a valid bit and loads when it is
   // empty or when the stage after it loads.
   localparam int ST_BACK = 0;                       // backgrounds over white
   localparam int ST_INK  = 1;                       // ink over backgrounds
   localparam int ST_LUMA = 2;                       // luminance, three stages
   localparam int ST_HILO = ST_LUMA + LUMA_STAGES;   // order and add 0.05
   localparam int ST_DIV  = ST_HILO + 1;             // divider stages
   localparam int ST_OUT  = ST_DIV + DIV_STAGES;     // response register
   localparam int NUM_ST  = ST_OUT + 1;

   localparam int BLEND_W = 2 * CHANNEL_BITS + 1;

   // ------------------------------------------------------------------
   // Register file
   // ------------------------------------------------------------------
   logic          hcm_ff;
   logic          hcm_in;
   ratio_type     min_ratio_ff;
   ratio_type     min_ratio_in;
   logic          csr_write;
   csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:CSR_INDEX_LSB]);

   always_comb begin
      hcm_in       = hcm_ff;
      min_ratio_in = min_ratio_ff;
      csr_prdata   = '0;
      case (csr_index)
         CSR_HIGH_CONTRAST: begin
            csr_prdata = CSR_DATA_W'(hcm_ff);
            if (csr_write) begin
               hcm_in = csr_pwdata[0];
            end
         end
         CSR_MIN_RATIO: begin
            csr_prdata = CSR_DATA_W'(min_ratio_ff);
            if (csr_write) begin
               min_ratio_in = csr_pwdata[RATIO_BITS-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hcm_ff       <= 1'b0;
         min_ratio_ff <= MIN_RATIO_RESET;
      end else begin
         hcm_ff       <= hcm_in;
         min_ratio_ff <= min_ratio_in;
      end
   end

   // ------------------------------------------------------------------
   // Flow control
   // ------------------------------------------------------------------
   logic [NUM_ST-1:0] valid_ff;
   logic [NUM_ST-1:0] valid_in;
   logic [NUM_ST-1:0] stage_en;
   logic [ST_OUT-1:0] transl_ff;

   always_comb begin
      stage_en[NUM_ST-1] = !valid_ff[NUM_ST-1] || !rsp_stall;
      for (int k = NUM_ST - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      for (int k = 0; k < NUM_ST; k++) begin
         if (!stage_en[k]) begin
            valid_in[k] = valid_ff[k];
         end else if (k == 0) begin
            valid_in[k] = req_valid;
         end else begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   assign req_stall = !stage_en[ST_BACK];
   assign rsp_valid = valid_ff[ST_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Translucent-ink flag rides alongside the data up to the response stage.
   always_ff @(posedge clock) begin
      if (stage_en[ST_BACK]) begin
         transl_ff[ST_BACK] <= (req_ink_alpha != CHAN_FULL);
      end
      for (int k = 1; k < ST_OUT; k++) begin
         if (stage_en[k]) begin
            transl_ff[k] <= transl_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Compositing: (x*a + u*(M-a) + (M-1)/2) / M, with the divide by M done
   // as (v + 1 + (v >> B)) >> B, which is exact over this range.
   // ------------------------------------------------------------------
   function automatic chan_type blend(input chan_type x, input chan_type a,
                                      input chan_type u);
      logic [BLEND_W-1:0] acc;
      logic [BLEND_W-1:0] quo;
      acc = BLEND_W'(x) * BLEND_W'(a)
          + BLEND_W'(u) * BLEND_W'(CHAN_FULL - a)
          + BLEND_W'(CH_HALF);
      quo = (acc + BLEND_W'(1) + (acc >> CHANNEL_BITS)) >> CHANNEL_BITS;
      return quo[CHANNEL_BITS-1:0];
   endfunction

   rgb_type  req_ink;
   rgb_type  req_back;
   rgb_type  req_alt;
   rgb_type  back_in;
   rgb_type  alt_in;
   rgb_type  s0_back_ff;
   rgb_type  s0_alt_ff;
   rgb_type  s0_ink_ff;
   chan_type s0_ink_alpha_ff;
   rgb_type  ink_back_in;
   rgb_type  ink_alt_in;
   rgb_type  s1_ink_back_ff;
   rgb_type  s1_ink_alt_ff;
   rgb_type  s1_back_ff;
   rgb_type  s1_alt_ff;

   assign req_ink  = {req_ink_blue, req_ink_green, req_ink_red};
   assign req_back = {req_back_blue, req_back_green, req_back_red};
   assign req_alt  = {req_alt_blue, req_alt_green, req_alt_red};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         back_in[i]     = blend(req_back[i], req_back_alpha, CHAN_FULL);
         alt_in[i]      = blend(req_alt[i], req_alt_alpha, CHAN_FULL);
         ink_back_in[i] = blend(s0_ink_ff[i], s0_ink_alpha_ff, s0_back_ff[i]);
         ink_alt_in[i]  = blend(s0_ink_ff[i], s0_ink_alpha_ff, s0_alt_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_BACK]) begin
         s0_back_ff      <= back_in;
         s0_alt_ff       <= alt_in;
         s0_ink_ff       <= req_ink;
         s0_ink_alpha_ff <= req_ink_alpha;
      end
      if (stage_en[ST_INK]) begin
         s1_ink_back_ff <= ink_back_in;
         s1_ink_alt_ff  <= ink_alt_in;
         s1_back_ff     <= s0_back_ff;
         s1_alt_ff      <= s0_alt_ff;
      end
   end

   // ------------------------------------------------------------------
   // Luminance of the four opaque colors
   // ------------------------------------------------------------------
   luma_type lum_ink_back;
   luma_type lum_back;
   luma_type lum_ink_alt;
   luma_type lum_alt;

   tcrc_luma u_luma_ink_back (
      .clock    (clock),
      .stage_en (stage_en[ST_LUMA +: LUMA_STAGES]),
      .rgb      (s1_ink_back_ff),
      .luma     (lum_ink_back)
   );

   tcrc_luma u_luma_back (
      .clock    (clock),
      .stage_en (stage_en[ST_LUMA +: LUMA_STAGES]),
      .rgb      (s1_back_ff),
      .luma     (lum_back)
   );

   tcrc_luma u_luma_ink_alt (
      .clock    (clock),
      .stage_en (stage_en[ST_LUMA +: LUMA_STAGES]),
      .rgb      (s1_ink_alt_ff),
      .luma     (lum_ink_alt)
   );

   tcrc_luma u_luma_alt (
      .clock    (clock),
      .stage_en (stage_en[ST_LUMA +: LUMA_STAGES]),
      .rgb      (s1_alt_ff),
      .luma     (lum_alt)
   );

   // ------------------------------------------------------------------
   // Brighter and darker term, each plus 0.05
   // ------------------------------------------------------------------
   luma_type hi_main_ff;
   luma_type lo_main_ff;
   luma_type hi_alt_ff;
   luma_type lo_alt_ff;
   luma_type hi_main_in;
   luma_type lo_main_in;
   luma_type hi_alt_in;
   luma_type lo_alt_in;

   always_comb begin
      if (lum_ink_back > lum_back) begin
         hi_main_in = lum_ink_back + LUMA_OFF;
         lo_main_in = lum_back + LUMA_OFF;
      end else begin
         hi_main_in = lum_back + LUMA_OFF;
         lo_main_in = lum_ink_back + LUMA_OFF;
      end
      if (lum_ink_alt > lum_alt) begin
         hi_alt_in = lum_ink_alt + LUMA_OFF;
         lo_alt_in = lum_alt + LUMA_OFF;
      end else begin
         hi_alt_in = lum_alt + LUMA_OFF;
         lo_alt_in = lum_ink_alt + LUMA_OFF;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_HILO]) begin
         hi_main_ff <= hi_main_in;
         lo_main_ff <= lo_main_in;
         hi_alt_ff  <= hi_alt_in;
         lo_alt_ff  <= lo_alt_in;
      end
   end

   // ------------------------------------------------------------------
   // Ratio division
   // ------------------------------------------------------------------
   ratio_type quot_main;
   ratio_type quot_alt;

   tcrc_div u_div_main (
      .clock    (clock),
      .stage_en (stage_en[ST_DIV +: DIV_STAGES]),
      .hi       (hi_main_ff),
      .lo       (lo_main_ff),
      .quot     (quot_main)
   );

   tcrc_div u_div_alt (
      .clock    (clock),
      .stage_en (stage_en[ST_DIV +: DIV_STAGES]),
      .hi       (hi_alt_ff),
      .lo       (lo_alt_ff),
      .quot     (quot_alt)
   );

   // ------------------------------------------------------------------
   // Response register: saturate at 21.0 and apply the threshold.
   // ------------------------------------------------------------------
   ratio_type ratio_main_in;
   ratio_type ratio_alt_in;
   logic      unreadable_in;
   logic      clear_in;
   ratio_type ratio_main_ff;
   ratio_type ratio_alt_ff;
   logic      unreadable_ff;
   logic      clear_ff;

   always_comb begin
      ratio_main_in = (quot_main > RATIO_CAP) ? RATIO_CAP : quot_main;
      ratio_alt_in  = (quot_alt > RATIO_CAP) ? RATIO_CAP : quot_alt;
      unreadable_in = transl_ff[ST_OUT-1]
                   || (ratio_main_in < min_ratio_ff)
                   || (ratio_alt_in < min_ratio_ff);
      clear_in      = hcm_ff || unreadable_in;
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         ratio_main_ff <= ratio_main_in;
         ratio_alt_ff  <= ratio_alt_in;
         unreadable_ff <= unreadable_in;
         clear_ff      <= clear_in;
      end
   end

   assign rsp_ratio_main   = ratio_main_ff;
   assign rsp_ratio_alt    = ratio_alt_ff;
   assign rsp_unreadable   = unreadable_ff;
   assign rsp_clear_format = clear_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // The brighter term is always divided by the darker one, so a ratio
   // below 1.0 means the ordering stage or the divider went wrong.
   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ratio_main >= RATIO_ONE) && (rsp_ratio_main <= RATIO_CAP)
                 && (rsp_ratio_alt >= RATIO_ONE) && (rsp_ratio_alt <= RATIO_CAP))
      else $error("contrast ratio outside 1.0 to 21.0");

   // A ratio under the threshold must be flagged.
   a_low_flagged: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_ratio_main < min_ratio_ff) || (rsp_ratio_alt < min_ratio_ff))
      |-> rsp_unreadable)
      else $error("low contrast not flagged unreadable");

   // High-contrast mode and unreadable colors both clear the format.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (hcm_ff || rsp_unreadable) |-> rsp_clear_format)
      else $error("clear_format missing");

   // An accepted request beat always lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[ST_BACK])
      else $error("accepted beat lost at pipeline entry");

endmodule

FILE: hdl/tcrc_luma.sv
// Relative luminance of one opaque color: table lookup, weighted sum,
// then division by 10000 through a reciprocal multiply.
module tcrc_luma import tcrc_pkg::*; (
   input  logic                   clock,
   input  logic [LUMA_STAGES-1:0] stage_en,
   input  rgb_type                rgb,
   output luma_type               luma
);

   luma_type [2:0]          lin_ff;
   luma_type [2:0]          lin_in;
   logic [LUMA_SUM_W-1:0]   sum_ff;
   logic [LUMA_SUM_W-1:0]   sum_in;
   logic [LUMA_PROD_W-1:0]  prod;
   luma_type                luma_ff;
   luma_type                luma_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lin_in[i] = LIN_ROM[rgb[i]];
      end
      sum_in = LUMA_SUM_W'(lin_ff[0]) * LUMA_SUM_W'(W_RED)
             + LUMA_SUM_W'(lin_ff[1]) * LUMA_SUM_W'(W_GREEN)
             + LUMA_SUM_W'(lin_ff[2]) * LUMA_SUM_W'(W_BLUE)
             + LUMA_SUM_W'(LUMA_ROUND);
      prod    = LUMA_PROD_W'(sum_ff) * LUMA_PROD_W'(LUMA_RECIP);
      luma_in = prod[LUMA_RECIP_SHIFT +: LUMA_W];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         lin_ff <= lin_in;
      end
      if (stage_en[1]) begin
         sum_ff <= sum_in;
      end
      if (stage_en[2]) begin
         luma_ff <= luma_in;
      end
   end

   assign luma = luma_ff;

endmodule

FILE: hdl/tcrc_div.sv
// Pipelined restoring divider: quot = floor((hi << RATIO_FRAC_BITS) / lo).
// The caller guarantees hi < 32 * lo, so the quotient fits RATIO_BITS.
module tcrc_div import tcrc_pkg::*; (
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] stage_en,
   input  luma_type              hi,
   input  luma_type              lo,
   output ratio_type             quot
);

   luma_type  rem_ff [DIV_STAGES];
   luma_type  rem_in [DIV_STAGES];
   ratio_type dq_ff  [DIV_STAGES];
   ratio_type dq_in  [DIV_STAGES];
   luma_type  lo_ff  [DIV_STAGES];
   luma_type  lo_in  [DIV_STAGES];

   // dq holds the dividend bits still to be brought down in its upper part
   // and the quotient bits found so far in its lower part.
   always_comb begin
      logic [LUMA_W:0] part;
      luma_type        rem;
      ratio_type       dq;
      luma_type        dvs;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            rem = hi >> RATIO_INT_BITS;
            dq  = {hi[RATIO_INT_BITS-1:0], {RATIO_FRAC_BITS{1'b0}}};
            dvs = lo;
         end else begin
            rem = rem_ff[s-1];
            dq  = dq_ff[s-1];
            dvs = lo_ff[s-1];
         end
         for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
            if (s * DIV_STEPS_PER_STAGE + j < RATIO_BITS) begin
               part = {rem, dq[RATIO_BITS-1]};
               dq   = {dq[RATIO_BITS-2:0], 1'b0};
               if (part >= {1'b0, dvs}) begin
                  part  = part - {1'b0, dvs};
                  dq[0] = 1'b1;
               end
               rem = part[LUMA_W-1:0];
            end
         end
         rem_in[s] = rem;
         dq_in[s]  = dq;
         lo_in[s]  = dvs;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (stage_en[s]) begin
            rem_ff[s] <= rem_in[s];
            dq_ff[s]  <= dq_in[s];
            lo_ff[s]  <= lo_in[s];
         end
      end
   end

   assign quot = dq_ff[DIV_STAGES-1];

endmodule

FILE: test/text_contrast_readability_check_test.sv
module text_contrast_readability_check_test;
   import tcrc_pkg::*;

   // One RGBA color, one request beat (three colors) and one response beat.
   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      chan_type alpha;
   } rgba_type;

   typedef struct packed {
      rgba_type ink;
      rgba_type back;
      rgba_type alt;
   } color_set_type;

   typedef struct packed {
      logic      clear_format;
      logic      unreadable;
      ratio_type ratio_main;
      ratio_type ratio_alt;
   } verdict_type;

   // A directed row either carries its verdict typed in or leaves it to the
   // contrast predictor.
   typedef struct packed {
      color_set_type colors;
      logic          typed;
      verdict_type   verdict;
   } stim_row_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_LIGHT,
      IDLE_HEAVY
   } idle_mode_type;

   localparam longint unsigned ONE_Q30 = 64'd1 << 30;

   // Black against white misses the 21.0 cap by one LSB because of the
   // rounding of the 0.05 flare term.
   localparam ratio_type FULL_SPAN = ratio_type'(5375);

   localparam int PHASES           = 7;
   localparam int RANDOM_PER_PHASE = 133;
   localparam int DRAIN_SLACK      = 16;
   localparam int PRESSURE_AT      = 250;
   localparam int PRESSURE_CYCLES  = 150;

   // Register settings per phase. Upper bits of the data word are set in one
   // phase to show that only the register width is kept.
   localparam logic [CSR_DATA_W-1:0] HC_WORDS [PHASES] = '{
      32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFE, 32'h0000_0000,
      32'h0000_0001, 32'h0000_0000, 32'h0000_0000
   };
   localparam logic [CSR_DATA_W-1:0] RATIO_WORDS [PHASES] = '{
      32'd1152, 32'd0, 32'hFFFF_FFFF, 32'd256, 32'd5376, 32'd768, 32'd1152
   };
   localparam idle_mode_type PHASE_IDLE [PHASES] = '{
      IDLE_LIGHT, IDLE_LIGHT, IDLE_HEAVY, IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT,
      IDLE_NONE
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   color_set_type         req_colors  = '0;
   logic                  rsp_stall   = 1'b0;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;

   logic                  req_stall;
   logic                  rsp_valid;
   logic                  rsp_clear_format;
   logic                  rsp_unreadable;
   ratio_type             rsp_ratio_main;
   ratio_type             rsp_ratio_alt;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Mirror of the two registers, as the block should hold them.
   logic      hc_mode   = 1'b0;
   ratio_type min_level = MIN_RATIO_RESET;

   // Linear light per channel code, Q0.16.
   longint unsigned lin_light [CH_LEVELS];

   verdict_type   pending_verdicts [$];
   stim_row_type  directed_rows [$];
   idle_mode_type idle_mode     = IDLE_LIGHT;
   int unsigned   stall_left    = 0;
   int unsigned   verdicts_seen = 0;
   int unsigned   errors        = 0;

   text_contrast_readability_check dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ink_red      (req_colors.ink.red),
      .req_ink_green    (req_colors.ink.green),
      .req_ink_blue     (req_colors.ink.blue),
      .req_ink_alpha    (req_colors.ink.alpha),
      .req_back_red     (req_colors.back.red),
      .req_back_green   (req_colors.back.green),
      .req_back_blue    (req_colors.back.blue),
      .req_back_alpha   (req_colors.back.alpha),
      .req_alt_red      (req_colors.alt.red),
      .req_alt_green    (req_colors.alt.green),
      .req_alt_blue     (req_colors.alt.blue),
      .req_alt_alpha    (req_colors.alt.alpha),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_clear_format (rsp_clear_format),
      .rsp_unreadable   (rsp_unreadable),
      .rsp_ratio_main   (rsp_ratio_main),
      .rsp_ratio_alt    (rsp_ratio_alt),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The sRGB transfer curve. Below the knee it is a straight line; above it
   // ((c + 0.055) / 1.055) ^ 2.4 is formed as t^2 times the fifth root of t^2,
   // the root being searched bit by bit in Q30.
   initial begin : build_lin_light
      longint unsigned m;
      longint unsigned cc;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned y;
      longint unsigned cand;
      longint unsigned y2;
      longint unsigned y4;
      longint unsigned r;
      m = CH_MAX;
      for (int c = 0; c < CH_LEVELS; c++) begin
         cc = c;
         if (cc * 100000 <= 3928 * m) begin
            lin_light[c] = (((cc * 100) << LUMA_FRAC_BITS) + (m * 1292) / 2) / (m * 1292);
         end else begin
            t = (((1000 * cc + 55 * m) << 30) + (1055 * m) / 2) / (1055 * m);
            if (t > ONE_Q30) begin
               t = ONE_Q30;
            end
            t2 = (t * t) >> 30;
            y  = 0;
            for (int b = 30; b >= 0; b--) begin
               cand = y | (64'd1 << b);
               if (cand <= ONE_Q30) begin
                  y2 = (cand * cand) >> 30;
                  y4 = (y2 * y2) >> 30;
                  if (((y4 * cand) >> 30) <= t2) begin
                     y = cand;
                  end
               end
            end
            r = (t2 * y) >> 30;
            lin_light[c] = (r + (64'd1 << (29 - LUMA_FRAC_BITS))) >> (30 - LUMA_FRAC_BITS);
         end
      end
   end

   function automatic rgba_type rgba(input chan_type r, input chan_type g,
                                     input chan_type b, input chan_type a);
      return '{r, g, b, a};
   endfunction

   // Composite x with opacity a over an opaque u, rounded to nearest.
   function automatic longint unsigned over(input longint unsigned x,
                                            input longint unsigned a,
                                            input longint unsigned u);
      longint unsigned m;
      m = CH_MAX;
      return (x * a + u * (m - a) + (m - 1) / 2) / m;
   endfunction

   function automatic longint unsigned luma_of(input longint unsigned r,
                                               input longint unsigned g,
                                               input longint unsigned b);
      return (2126 * lin_light[r] + 7152 * lin_light[g] + 722 * lin_light[b] + 5000)
             / 10000;
   endfunction

   // The background goes over white first, then the ink over that background.
   function automatic ratio_type ratio_of(input rgba_type ink, input rgba_type bg);
      longint unsigned br, bgr, bb;
      longint unsigned li, lb, off, hi, lo, q, cap;
      br  = over(bg.red, bg.alpha, CH_MAX);
      bgr = over(bg.green, bg.alpha, CH_MAX);
      bb  = over(bg.blue, bg.alpha, CH_MAX);
      li  = luma_of(over(ink.red, ink.alpha, br), over(ink.green, ink.alpha, bgr),
                    over(ink.blue, ink.alpha, bb));
      lb  = luma_of(br, bgr, bb);
      off = ((64'd1 << LUMA_FRAC_BITS) + 10) / 20;
      hi  = (li > lb ? li : lb) + off;
      lo  = (li > lb ? lb : li) + off;
      q   = (hi << RATIO_FRAC_BITS) / lo;
      cap = 64'd21 << RATIO_FRAC_BITS;
      return ratio_type'(q > cap ? cap : q);
   endfunction

   function automatic verdict_type judge_colors(input color_set_type cs);
      verdict_type v;
      v.ratio_main   = ratio_of(cs.ink, cs.back);
      v.ratio_alt    = ratio_of(cs.ink, cs.alt);
      v.unreadable   = cs.ink.alpha != CHAN_FULL || v.ratio_main < min_level
                       || v.ratio_alt < min_level;
      v.clear_format = hc_mode | v.unreadable;
      return v;
   endfunction

   // Often no gap, never one in IDLE_NONE; sometimes short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (idle_mode == IDLE_NONE) begin
         return 0;
      end
      if (roll < (idle_mode == IDLE_HEAVY ? 45 : 70)) begin
         return 0;
      end
      if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic chan_type draw_level();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         return '0;
      end
      if (roll < 16) begin
         return CHAN_FULL;
      end
      return chan_type'($urandom_range(0, CH_MAX));
   endfunction

   // Random color sets. Opaque ink dominates so that the readable verdict
   // hangs on the ratios; grey on grey lands close to the thresholds.
   function automatic color_set_type draw_colors();
      color_set_type cs;
      int unsigned   kind;
      chan_type      grey;
      kind    = $urandom_range(0, 99);
      cs.ink  = rgba(draw_level(), draw_level(), draw_level(), CHAN_FULL);
      cs.back = rgba(draw_level(), draw_level(), draw_level(), CHAN_FULL);
      cs.alt  = rgba(draw_level(), draw_level(), draw_level(), CHAN_FULL);
      if (kind < 20) begin
         grey    = draw_level();
         cs.ink  = rgba(grey, grey, grey, CHAN_FULL);
         grey    = draw_level();
         cs.back = rgba(grey, grey, grey, CHAN_FULL);
         grey    = draw_level();
         cs.alt  = rgba(grey, grey, grey, CHAN_FULL);
      end else if (kind < 50) begin
         cs.ink.alpha = CHAN_FULL;
      end else if (kind < 75) begin
         cs.back.alpha = draw_level();
         cs.alt.alpha  = draw_level();
      end else if (kind < 90) begin
         cs.ink.alpha  = draw_level();
         cs.back.alpha = draw_level();
         cs.alt.alpha  = draw_level();
      end else begin
         cs = color_set_type'({$urandom, $urandom, $urandom});
      end
      return cs;
   endfunction

   task automatic queue_directed(input rgba_type ink, input rgba_type back,
                                 input rgba_type alt, input logic typed,
                                 input verdict_type verdict);
      stim_row_type row;
      row.colors  = '{ink, back, alt};
      row.typed   = typed;
      row.verdict = verdict;
      directed_rows.push_back(row);
   endtask

   // Offers one request beat after a random gap and holds it until taken.
   // Valid is only lowered when a gap follows, so back-to-back beats never
   // see valid dropped and raised in the same step.
   task automatic offer_row(input stim_row_type row);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_colors <= row.colors;
      do @(posedge clock); while (req_stall);
      pending_verdicts.push_back(row.typed ? row.verdict : judge_colors(row.colors));
   endtask

   // Waits for every pending response, then lets the pipeline settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // Writes a register, then reads it back within the same selection. The
   // port then idles with select low, so a following access starts on a
   // fresh edge.
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] word);
      logic [CSR_DATA_W-1:0] mask;
      logic [CSR_DATA_W-1:0] stored;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << CSR_INDEX_LSB;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == CSR_HIGH_CONTRAST) begin
         hc_mode = word[0];
         mask    = CSR_DATA_W'(1);
         stored  = CSR_DATA_W'(hc_mode);
      end else begin
         min_level = word[RATIO_BITS-1:0];
         mask      = CSR_DATA_W'((1 << RATIO_BITS) - 1);
         stored    = CSR_DATA_W'(min_level);
      end
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if ((csr_prdata & mask) !== stored) begin
         $error("register %s readback: expected %0d, got %0d", idx.name(), stored,
                csr_prdata & mask);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Compares a taken response beat with the oldest pending verdict.
   task automatic check_verdict();
      verdict_type want;
      if (pending_verdicts.size() == 0) begin
         $error("response beat with no request pending");
         errors++;
         return;
      end
      want = pending_verdicts.pop_front();
      verdicts_seen++;
      if (rsp_clear_format !== want.clear_format) begin
         $error("clear_format: expected %0d, got %0d", want.clear_format, rsp_clear_format);
         errors++;
      end
      if (rsp_unreadable !== want.unreadable) begin
         $error("unreadable: expected %0d, got %0d", want.unreadable, rsp_unreadable);
         errors++;
      end
      if (rsp_ratio_main !== want.ratio_main) begin
         $error("ratio_main: expected %0d, got %0d", want.ratio_main, rsp_ratio_main);
         errors++;
      end
      if (rsp_ratio_alt !== want.ratio_alt) begin
         $error("ratio_alt: expected %0d, got %0d", want.ratio_alt, rsp_ratio_alt);
         errors++;
      end
   endtask

   // Response side. Outputs are sampled right after the edge, so they still
   // hold the values that the edge acted on. Stall runs come from the same gap
   // picker as the request side; once, a long hold-off lets the pipeline fill
   // up while requests keep coming, so that the block stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            check_verdict();
            if (verdicts_seen == PRESSURE_AT) begin
               stall_left = PRESSURE_CYCLES;
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = pick_gap();
            if (stall_left != 0) begin
               stall_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin : stimulus
      stim_row_type row;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows, run at the reset settings (threshold 4.5, mode off).
      // Black ink on white, white on white and white on black.
      queue_directed(rgba(0, 0, 0, 255), rgba(255, 255, 255, 255),
                     rgba(255, 255, 255, 255), 1'b1, '{1'b0, 1'b0, FULL_SPAN, FULL_SPAN});
      queue_directed(rgba(255, 255, 255, 255), rgba(255, 255, 255, 255),
                     rgba(255, 255, 255, 255), 1'b1, '{1'b1, 1'b1, RATIO_ONE, RATIO_ONE});
      queue_directed(rgba(255, 255, 255, 255), rgba(0, 0, 0, 255),
                     rgba(0, 0, 0, 255), 1'b1, '{1'b0, 1'b0, FULL_SPAN, FULL_SPAN});
      // Fully transparent ink vanishes into the white background.
      queue_directed(rgba(0, 0, 0, 0), rgba(255, 255, 255, 255),
                     rgba(255, 255, 255, 255), 1'b1, '{1'b1, 1'b1, RATIO_ONE, RATIO_ONE});
      // Ink one step short of opaque is unreadable whatever its ratios.
      queue_directed(rgba(0, 0, 0, 254), rgba(255, 255, 255, 255),
                     rgba(255, 255, 255, 255), 1'b0, '0);
      // Transparent backgrounds turn white.
      queue_directed(rgba(0, 0, 0, 255), rgba(0, 0, 0, 0),
                     rgba(255, 255, 255, 255), 1'b1, '{1'b0, 1'b0, FULL_SPAN, FULL_SPAN});
      queue_directed(rgba(255, 255, 255, 255), rgba(0, 0, 0, 255),
                     rgba(0, 0, 0, 0), 1'b1, '{1'b1, 1'b1, FULL_SPAN, RATIO_ONE});
      // Every field at zero, then every field at full scale.
      queue_directed(rgba(0, 0, 0, 0), rgba(0, 0, 0, 0), rgba(0, 0, 0, 0),
                     1'b1, '{1'b1, 1'b1, RATIO_ONE, RATIO_ONE});
      queue_directed(rgba(255, 255, 255, 255), rgba(255, 255, 255, 255),
                     rgba(255, 255, 255, 255), 1'b1, '{1'b1, 1'b1, RATIO_ONE, RATIO_ONE});
      // Codes on either side of the knee of the transfer curve.
      queue_directed(rgba(10, 10, 10, 255), rgba(255, 255, 255, 255),
                     rgba(0, 0, 0, 255), 1'b0, '0);
      queue_directed(rgba(11, 11, 11, 255), rgba(255, 255, 255, 255),
                     rgba(0, 0, 0, 255), 1'b0, '0);
      // Primaries, to exercise each luminance weight alone.
      queue_directed(rgba(255, 0, 0, 255), rgba(255, 255, 255, 255),
                     rgba(0, 0, 0, 255), 1'b0, '0);
      queue_directed(rgba(0, 255, 0, 255), rgba(255, 255, 255, 255),
                     rgba(0, 0, 0, 255), 1'b0, '0);
      queue_directed(rgba(0, 0, 255, 255), rgba(255, 255, 255, 255),
                     rgba(0, 0, 0, 255), 1'b0, '0);
      // Greys around the default threshold against white.
      queue_directed(rgba(117, 117, 117, 255), rgba(255, 255, 255, 255),
                     rgba(255, 255, 255, 255), 1'b0, '0);
      queue_directed(rgba(118, 118, 118, 255), rgba(255, 255, 255, 255),
                     rgba(255, 255, 255, 255), 1'b0, '0);
      queue_directed(rgba(119, 119, 119, 255), rgba(255, 255, 255, 255),
                     rgba(255, 255, 255, 255), 1'b0, '0);
      // Alternating bit patterns in every field.
      queue_directed(rgba(8'hAA, 8'h55, 8'hAA, 8'hFF), rgba(8'h55, 8'hAA, 8'h55, 8'hFF),
                     rgba(8'hAA, 8'hAA, 8'h55, 8'h80), 1'b0, '0);
      queue_directed(rgba(8'h55, 8'hAA, 8'h55, 8'h55), rgba(8'hAA, 8'h55, 8'hAA, 8'hAA),
                     rgba(8'h55, 8'h55, 8'hAA, 8'hFF), 1'b0, '0);
      // Half-transparent ink over black, and nearly clear or nearly opaque
      // backgrounds.
      queue_directed(rgba(255, 0, 0, 128), rgba(0, 0, 0, 255),
                     rgba(0, 0, 0, 127), 1'b0, '0);
      queue_directed(rgba(0, 0, 0, 255), rgba(40, 90, 200, 1),
                     rgba(40, 90, 200, 254), 1'b0, '0);
      foreach (directed_rows[i]) begin
         offer_row(directed_rows[i]);
      end

      // Random phases, each with its own register settings and idle mode.
      // Registers change only once the pipeline has emptied.
      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_csr(CSR_HIGH_CONTRAST, HC_WORDS[p]);
         write_csr(CSR_MIN_RATIO, RATIO_WORDS[p]);
         idle_mode = PHASE_IDLE[p];
         repeat (RANDOM_PER_PHASE) begin
            row.colors  = draw_colors();
            row.typed   = 1'b0;
            row.verdict = '0;
            offer_row(row);
         end
      end

      drain();
      if (errors == 0) begin
         $display("text_contrast_readability_check verification clean");
      end else begin
         $display("text_contrast_readability_check verification failed");
      end
      $finish;
   end

   // A correct run needs well under a tenth of this time.
   initial begin : watchdog
      #5_000_000;
      $display("text_contrast_readability_check verification failed");
      $finish;
   end

endmodule
